### rtl/isort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared sizes, types and state codes for the insertion sorter cell chain.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int SWAP_W      = 11;
    localparam int IN_W        = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELD_W = DATA_WIDTH + SWAP_W + 1;
    localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int SWAP_LSB    = DATA_WIDTH;
    localparam int OVF_BIT     = DATA_WIDTH + SWAP_W;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic load;
        logic walk;
        logic shift;
        logic desc;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN
    } t_state;

endpackage

### rtl/insertion_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter
// Sorts a run of signed values in a chain of cells by stable insertion and
// streams the sorted run out with the inversion count and an overflow flag.
// ----------------------------------------------------------------------------
// Values enter on the slave stream, one request per value, with tlast on the
// final value of a run. The order bit must be written on the configuration
// channel only between runs; the block does not enforce this. The bit applies
// to every later insertion. Each value is loaded into the first free cell and
// then walks toward the head one cell per cycle, one adjacent swap per cycle;
// the input is not ready again until a walk step makes no swap.
// A value that finds all cells full is dropped and sets the overflow flag.
// After the final value has settled, the chain shifts toward the head and the
// run is read out through an output register at one result per cycle; every
// result carries the swap count and the overflow flag, and the last one has
// tlast. The input is held off during readout, and a stalled receiver stops
// the shifting without loss. The chain is empty again after the last result.
// Reset clears the run counters and the order bit; no clearing pass is needed.
// ----------------------------------------------------------------------------
module insertion_sorter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [isort_pkg::IN_W-1:0]    i_s_axis_tdata,   // value
    input  logic                          i_s_axis_tlast,   // last_in
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [isort_pkg::OUT_W-1:0]   o_m_axis_tdata,   // sorted_value, swap_count, overflow
    output logic                          o_m_axis_tlast,   // last_out
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data        // descending
);
    import isort_pkg::*;

    t_cell_ctl            w_ctl;
    t_data                w_key;
    logic [CNT_W-1:0]     w_fill;
    t_data                w_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] w_tok;
    logic [MAX_ITEMS-1:0] w_swap;
    logic [MAX_ITEMS-1:0] w_load;
    t_data                w_in_value;

    assign w_in_value = i_s_axis_tdata[DATA_WIDTH-1:0];

    isort_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_value         (w_in_value),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_ctl           (w_ctl),
        .o_key           (w_key),
        .o_fill          (w_fill),
        .i_any_swap      (|w_swap),
        .i_head          (w_value[0])
    );

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_data w_up_value;
        t_data w_dn_value;
        logic  w_tok_up;
        logic  w_dn_swap;

        assign w_load[g] = w_ctl.load & (w_fill == CNT_W'(g));

        if (g == MAX_ITEMS - 1) begin : g_top
            assign w_up_value = w_value[g];
            assign w_tok_up   = 1'b0;
        end else begin : g_mid
            assign w_up_value = w_value[g+1];
            assign w_tok_up   = w_tok[g+1];
        end

        if (g == 0) begin : g_head
            assign w_dn_value = w_value[g];
            assign w_dn_swap  = 1'b0;
        end else begin : g_rest
            assign w_dn_value = w_value[g-1];
            assign w_dn_swap  = w_swap[g-1];
        end

        isort_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load     (w_load[g]),
            .i_key      (w_key),
            .i_up_value (w_up_value),
            .i_dn_value (w_dn_value),
            .i_tok_up   (w_tok_up),
            .i_dn_swap  (w_dn_swap),
            .o_value    (w_value[g]),
            .o_tok      (w_tok[g]),
            .o_swap     (w_swap[g])
        );
    end

endmodule

### rtl/isort_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter cell
// One store entry. It swaps with its upper neighbor while the new item walks
// down, and shifts toward the head of the chain while the run is read out.
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  isort_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_load,
    input  isort_pkg::t_data      i_key,
    input  isort_pkg::t_data      i_up_value,
    input  isort_pkg::t_data      i_dn_value,
    input  logic                  i_tok_up,
    input  logic                  i_dn_swap,
    output isort_pkg::t_data      o_value,
    output logic                  o_tok,
    output logic                  o_swap
);
    import isort_pkg::*;

    t_data r_value;
    t_data n_value;
    logic  r_tok;
    logic  n_tok;
    logic  w_ooo;

    always_comb begin
        w_ooo  = i_ctl.desc ? (r_value < i_key) : (r_value > i_key);
        o_swap = i_ctl.walk & i_tok_up & w_ooo;
        n_tok  = i_load | o_swap;
        if (i_load || o_swap) begin
            n_value = i_key;
        end else if (i_dn_swap) begin
            n_value = i_dn_value;
        end else if (i_ctl.shift) begin
            n_value = i_up_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tok   = r_tok;

endmodule

### rtl/isort_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter control
// Sequences load, walk and readout, keeps the run counters and the order bit,
// and holds the output register.
// ----------------------------------------------------------------------------
module isort_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  isort_pkg::t_data              i_value,
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [isort_pkg::OUT_W-1:0]   o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output isort_pkg::t_cell_ctl          o_ctl,
    output isort_pkg::t_data              o_key,
    output logic [isort_pkg::CNT_W-1:0]   o_fill,
    input  logic                          i_any_swap,
    input  isort_pkg::t_data              i_head
);
    import isort_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic                r_desc;
    t_data               r_key;
    logic                r_last;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    r_left;
    logic [SWAP_W-1:0]   r_swaps;
    logic                r_drop;
    logic                r_out_valid;
    t_data               r_out_value;
    logic                r_out_last;
    logic [SWAP_W-1:0]   r_out_swaps;
    logic                r_out_drop;
    logic                w_acc;
    logic                w_room;
    logic                w_take;
    logic                w_final;

    assign w_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_room  = r_fill < CNT_W'(MAX_ITEMS);
    assign w_take  = (r_state == S_DRAIN) & (!r_out_valid | i_m_axis_tready)
                     & (r_left != '0);
    assign w_final = w_take & (r_left == CNT_W'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_room) begin
                        n_state = S_WALK;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_WALK: begin
                if (!i_any_swap) begin
                    n_state = r_last ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (w_final) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_ctl.load      = w_acc & w_room;
        o_ctl.walk      = (r_state == S_WALK);
        o_ctl.shift     = w_take;
        o_ctl.desc      = r_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_desc      <= 1'b0;
            r_last      <= 1'b0;
            r_fill      <= '0;
            r_left      <= '0;
            r_swaps     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_desc <= i_cfg_data;
            end
            if (w_acc) begin
                r_last <= i_s_axis_tlast;
                if (w_room) begin
                    r_fill <= r_fill + CNT_W'(1);
                end else begin
                    r_drop <= 1'b1;
                    if (i_s_axis_tlast) begin
                        r_left <= r_fill;
                    end
                end
            end
            if (o_ctl.walk && i_any_swap && (r_swaps != '1)) begin
                r_swaps <= r_swaps + SWAP_W'(1);
            end
            if (o_ctl.walk && !i_any_swap && r_last) begin
                r_left <= r_fill;
            end
            if (w_take) begin
                r_left <= r_left - CNT_W'(1);
            end
            if (w_final) begin
                r_fill  <= '0;
                r_swaps <= '0;
                r_drop  <= 1'b0;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_key <= i_value;
        end
        if (w_take) begin
            r_out_value <= i_head;
            r_out_last  <= (r_left == CNT_W'(1));
            r_out_swaps <= r_swaps;
            r_out_drop  <= r_drop;
        end
    end

    // The loading cell takes the incoming value directly; the walk uses the held copy.
    assign o_key           = w_acc ? i_value : r_key;
    assign o_fill          = r_fill;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = OUT_W'({r_out_drop, r_out_swaps, r_out_value});

endmodule

### rtl/isort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter checker
// Port-level properties of the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module isort_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_s_axis_tready,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [isort_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input  logic                          o_m_axis_tlast
);
    import isort_pkg::*;

    localparam int SWAP_BOUND = MAX_ITEMS * (MAX_ITEMS - 1) / 2;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("Stalled result request changed.");

    a_readout_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("Input ready while a run is still being read out.");

    a_swap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[OVF_BIT-1:SWAP_LSB] <= SWAP_W'(SWAP_BOUND))
        else $error("Swap count exceeds the inversion bound.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("Block not idle after reset.");

endmodule

bind insertion_sorter_top isort_checker u_isort_checker (.*);
